@@ rtl/drcg_pkg.sv @@
package drcg_pkg;

  localparam int unsigned IDX_W   = 17;   // point index
  localparam int unsigned OPW     = 17;   // shared subtractor width
  localparam int unsigned RING_W  = 9;    // ring number, up to 256
  localparam int unsigned SIZE_W  = 11;   // points in one ring, up to 1024
  localparam int unsigned POS_W   = 10;
  localparam int unsigned GRID_W  = 11;
  localparam int unsigned RAD_W   = 8;
  localparam int unsigned COORD_W = 12;   // signed unreduced coordinate
  localparam int unsigned MAG_W   = 11;   // magnitude of an unreduced coordinate
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 11;

  localparam logic [GRID_W-1:0] GRID_MAX = GRID_W'(1024);

  localparam logic [CFG_AW-1:0] CFG_CENTRE_X   = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] CFG_CENTRE_Y   = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] CFG_RADIUS     = CFG_AW'(2);
  localparam logic [CFG_AW-1:0] CFG_GRID_WIDTH = CFG_AW'(3);
  localparam logic [CFG_AW-1:0] CFG_GRID_HEIGHT = CFG_AW'(4);
  localparam logic [CFG_AW-1:0] CFG_PERIODIC   = CFG_AW'(5);

  typedef struct packed {
    logic [POS_W-1:0]  centre_x;
    logic [POS_W-1:0]  centre_y;
    logic [RAD_W-1:0]  radius;
    logic [GRID_W-1:0] grid_width;
    logic [GRID_W-1:0] grid_height;
    logic              periodic;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             in_grid;
    logic             beyond_radius;
  } res_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RING = 7'b0000010,
    ST_OFFS = 7'b0000100,
    ST_MODX = 7'b0001000,
    ST_FIXX = 7'b0010000,
    ST_MODY = 7'b0100000,
    ST_FIXY = 7'b1000000
  } state_e;

  // grid size of 0 acts as 1, above the limit acts as the limit
  function automatic logic [GRID_W-1:0] clamp_grid(input logic [GRID_W-1:0] g);
    logic [GRID_W-1:0] r;
    r = g;
    if (g == '0) r = GRID_W'(1);
    else if (g > GRID_MAX) r = GRID_MAX;
    return r;
  endfunction

endpackage

@@ rtl/drcg_if.sv @@
interface drcg_in_if;
  logic                        valid;
  logic                        ready;
  logic [drcg_pkg::IDX_W-1:0]  point_index;
  modport source (output valid, output point_index, input ready);
  modport sink   (input valid, input point_index, output ready);
endinterface

interface drcg_out_if;
  logic                        valid;
  logic                        ready;
  logic [drcg_pkg::POS_W-1:0]  pos_x;
  logic [drcg_pkg::POS_W-1:0]  pos_y;
  logic                        in_grid;
  logic                        beyond_radius;
  modport source (output valid, output pos_x, output pos_y, output in_grid,
                  output beyond_radius, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input in_grid,
                  input beyond_radius, output ready);
endinterface

interface drcg_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [drcg_pkg::CFG_AW-1:0]  index;
  logic [drcg_pkg::CFG_DW-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/drcg_sub.sv @@
module drcg_sub (
  input  logic [drcg_pkg::OPW-1:0] a_i,
  input  logic [drcg_pkg::OPW-1:0] b_i,
  output logic [drcg_pkg::OPW-1:0] diff_o,
  output logic                     ge_o
);

  logic [drcg_pkg::OPW:0] full;

  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[drcg_pkg::OPW-1:0];
  assign ge_o   = ~full[drcg_pkg::OPW];

endmodule

@@ rtl/drcg_core.sv @@
module drcg_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  drcg_pkg::cfg_t             cfg_i,
  input  logic                       in_valid_i,
  input  logic [drcg_pkg::IDX_W-1:0] in_index_i,
  output logic                       in_ready_o,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output drcg_pkg::res_t             res_o
);

  localparam int unsigned OPW     = drcg_pkg::OPW;
  localparam int unsigned RING_W  = drcg_pkg::RING_W;
  localparam int unsigned SIZE_W  = drcg_pkg::SIZE_W;
  localparam int unsigned POS_W   = drcg_pkg::POS_W;
  localparam int unsigned GRID_W  = drcg_pkg::GRID_W;
  localparam int unsigned COORD_W = drcg_pkg::COORD_W;
  localparam int unsigned MAG_W   = drcg_pkg::MAG_W;
  localparam int unsigned CNT_W   = drcg_pkg::CNT_W;

  drcg_pkg::state_e state_q, state_d;

  logic [drcg_pkg::IDX_W-1:0] rem_q, rem_d;
  logic [RING_W-1:0]  ring_q, ring_d;
  logic [SIZE_W-1:0]  size_q, size_d;
  logic [MAG_W-1:0]   mag_q, mag_d;
  logic [MAG_W-1:0]   ymag_q, ymag_d;
  logic               xneg_q, xneg_d;
  logic               yneg_q, yneg_d;
  logic [POS_W-1:0]   r_q, r_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  drcg_pkg::res_t     res_q, res_d;

  logic [OPW-1:0]     sub_a, sub_b, sub_diff;
  logic               sub_ge;

  logic [GRID_W-1:0]  wc, hc, mod_n;
  logic [MAG_W-1:0]   shifted;
  logic               neg_cur;

  // ring offset arithmetic
  logic [POS_W-1:0]   p;
  logic [SIZE_W-1:0]  p2, swap_lim;
  logic [RING_W-1:0]  m, dy;
  logic               sx, sy, swap, sxf, syf;
  logic [COORD_W-1:0] xoff, yoff, xs, ys;
  logic               outside;

  drcg_sub u_sub (
    .a_i    (sub_a),
    .b_i    (sub_b),
    .diff_o (sub_diff),
    .ge_o   (sub_ge)
  );

  assign wc = drcg_pkg::clamp_grid(cfg_i.grid_width);
  assign hc = drcg_pkg::clamp_grid(cfg_i.grid_height);

  assign mod_n   = (state_q == drcg_pkg::ST_MODX || state_q == drcg_pkg::ST_FIXX) ? wc : hc;
  assign neg_cur = (state_q == drcg_pkg::ST_FIXX) ? xneg_q : yneg_q;
  assign shifted = {r_q, mag_q[MAG_W-1]};

  always_comb begin
    p        = rem_q[POS_W-1:0];
    p2       = SIZE_W'(p) + SIZE_W'(2);
    m        = p2[SIZE_W-1:2];
    sx       = p2[1];
    sy       = p2[0];
    swap_lim = {ring_q, 2'b00} - SIZE_W'(2);
    swap     = (ring_q != '0) && (SIZE_W'(p) >= swap_lim);
    sxf      = swap ? sy : sx;
    syf      = swap ? sx : sy;
    if (m > ring_q) m = ring_q;   // centre point only
    dy       = ring_q - m;
    xoff     = sxf ? (COORD_W'(0) - COORD_W'(m)) : COORD_W'(m);
    yoff     = syf ? (COORD_W'(0) - COORD_W'(dy)) : COORD_W'(dy);
    xs       = COORD_W'(cfg_i.centre_x) + xoff;
    ys       = COORD_W'(cfg_i.centre_y) + yoff;
    outside  = xs[COORD_W-1] || (xs[MAG_W-1:0] >= wc) ||
               ys[COORD_W-1] || (ys[MAG_W-1:0] >= hc);
  end

  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (state_q)
      drcg_pkg::ST_RING: begin
        sub_a = OPW'(rem_q);
        sub_b = OPW'(size_q);
      end
      drcg_pkg::ST_MODX, drcg_pkg::ST_MODY: begin
        sub_a = OPW'(shifted);
        sub_b = OPW'(mod_n);
      end
      drcg_pkg::ST_FIXX, drcg_pkg::ST_FIXY: begin
        sub_a = OPW'(mod_n);
        sub_b = OPW'(r_q);
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    ring_d  = ring_q;
    size_d  = size_q;
    mag_d   = mag_q;
    ymag_d  = ymag_q;
    xneg_d  = xneg_q;
    yneg_d  = yneg_q;
    r_d     = r_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    case (state_q)
      drcg_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          rem_d   = in_index_i;
          ring_d  = '0;
          size_d  = SIZE_W'(1);
          state_d = drcg_pkg::ST_RING;
        end
      end
      drcg_pkg::ST_RING: begin
        if (sub_ge) begin
          rem_d  = sub_diff[drcg_pkg::IDX_W-1:0];
          ring_d = ring_q + RING_W'(1);
          size_d = {ring_d, 2'b00};
        end else begin
          state_d = drcg_pkg::ST_OFFS;
        end
      end
      drcg_pkg::ST_OFFS: begin
        xneg_d  = xs[COORD_W-1];
        yneg_d  = ys[COORD_W-1];
        mag_d   = xs[COORD_W-1] ? MAG_W'(COORD_W'(0) - xs) : xs[MAG_W-1:0];
        ymag_d  = ys[COORD_W-1] ? MAG_W'(COORD_W'(0) - ys) : ys[MAG_W-1:0];
        res_d.in_grid       = cfg_i.periodic || !outside;
        res_d.beyond_radius = ring_q > RING_W'(cfg_i.radius);
        r_d     = '0;
        cnt_d   = CNT_W'(MAG_W - 1);
        state_d = drcg_pkg::ST_MODX;
      end
      drcg_pkg::ST_MODX, drcg_pkg::ST_MODY: begin
        // restoring remainder, one magnitude bit per cycle
        r_d   = sub_ge ? sub_diff[POS_W-1:0] : shifted[POS_W-1:0];
        mag_d = {mag_q[MAG_W-2:0], 1'b0};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = (state_q == drcg_pkg::ST_MODX) ? drcg_pkg::ST_FIXX : drcg_pkg::ST_FIXY;
        end
      end
      drcg_pkg::ST_FIXX, drcg_pkg::ST_FIXY: begin
        // negative value: remainder folds to n - r
        if (state_q == drcg_pkg::ST_FIXX) begin
          res_d.pos_x = (neg_cur && r_q != '0) ? sub_diff[POS_W-1:0] : r_q;
          mag_d   = ymag_q;
          r_d     = '0;
          cnt_d   = CNT_W'(MAG_W - 1);
          state_d = drcg_pkg::ST_MODY;
        end else begin
          res_d.pos_y = (neg_cur && r_q != '0) ? sub_diff[POS_W-1:0] : r_q;
          if (res_valid_o && res_ready_i) state_d = drcg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = drcg_pkg::ST_IDLE;
      end
    endcase
  end

  // result beat leaves from the final fold cycle
  assign in_ready_o  = (state_q == drcg_pkg::ST_IDLE);
  assign res_valid_o = (state_q == drcg_pkg::ST_FIXY);

  always_comb begin
    res_o       = res_q;
    res_o.pos_y = (yneg_q && r_q != '0) ? sub_diff[POS_W-1:0] : r_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= drcg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    ring_q <= ring_d;
    size_q <= size_d;
    mag_q  <= mag_d;
    ymag_q <= ymag_d;
    xneg_q <= xneg_d;
    yneg_q <= yneg_d;
    r_q    <= r_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
  end

endmodule

@@ rtl/diamond_ring_coordinate_gen.sv @@
// channel | dir | payload                                   | accepted when
// in_i    | in  | point_index                               | valid && ready
// out_o   | out | pos_x, pos_y, in_grid, beyond_radius      | valid && ready
// cfg_i   | in  | index, data                               | valid && ready
//
// An item for ring d passes through the ring search on the shared subtractor, an offset
// step, a restoring remainder and a fold step for each coordinate, and the idle state;
// the final fold waits while the output register cannot take the result.
// Reset returns the config registers to their defaults and empties the output stage.
// A result waits in the output register; the next item is taken meanwhile.
// Config writes are always taken.
module diamond_ring_coordinate_gen (
  input  logic        clk_i,
  input  logic        rst_ni,
  drcg_in_if.sink     in_i,
  drcg_out_if.source  out_o,
  drcg_cfg_if.sink    cfg_i
);

  drcg_pkg::cfg_t cfg_q, cfg_d;
  drcg_pkg::res_t res, out_q;
  logic           res_valid, res_ready;
  logic           out_valid_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        drcg_pkg::CFG_CENTRE_X:    cfg_d.centre_x    = cfg_i.data[drcg_pkg::POS_W-1:0];
        drcg_pkg::CFG_CENTRE_Y:    cfg_d.centre_y    = cfg_i.data[drcg_pkg::POS_W-1:0];
        drcg_pkg::CFG_RADIUS:      cfg_d.radius      = cfg_i.data[drcg_pkg::RAD_W-1:0];
        drcg_pkg::CFG_GRID_WIDTH:  cfg_d.grid_width  = cfg_i.data[drcg_pkg::GRID_W-1:0];
        drcg_pkg::CFG_GRID_HEIGHT: cfg_d.grid_height = cfg_i.data[drcg_pkg::GRID_W-1:0];
        drcg_pkg::CFG_PERIODIC:    cfg_d.periodic    = cfg_i.data[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.centre_x    <= '0;
      cfg_q.centre_y    <= '0;
      cfg_q.radius      <= '0;
      cfg_q.grid_width  <= drcg_pkg::GRID_W'(64);
      cfg_q.grid_height <= drcg_pkg::GRID_W'(64);
      cfg_q.periodic    <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  drcg_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_index_i  (in_i.point_index),
    .in_ready_o  (in_i.ready),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pos_x         = out_q.pos_x;
  assign out_o.pos_y         = out_q.pos_y;
  assign out_o.in_grid       = out_q.in_grid;
  assign out_o.beyond_radius = out_q.beyond_radius;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while an item is in flight");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> out_o.valid)
    else $error("result beat lost at the output register");

  a_wrap_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready && cfg_q.periodic) |=> out_o.in_grid)
    else $error("point flagged off grid with wrap on");

  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !res_valid)
    else $error("result offered while idle");

endmodule

@@ tb/tb_diamond_ring_coordinate_gen.sv @@
module tb_diamond_ring_coordinate_gen;
  import drcg_pkg::*;

  localparam int unsigned IDX_MAX     = (1 << IDX_W) - 1;
  localparam int unsigned GRID_LIMIT  = 1024;
  localparam int          STALL_LIMIT = 4000;
  localparam int          DRAIN_WAIT  = 400;

  // indexes with no register behind them
  localparam logic [CFG_AW-1:0] CFG_UNMAPPED_A = CFG_AW'(6);
  localparam logic [CFG_AW-1:0] CFG_UNMAPPED_B = CFG_AW'(7);

  typedef struct {
    logic [IDX_W-1:0] idx;
    res_t             coord;
  } pending_t;

  logic clk = 1'b0;
  logic rst_n;

  drcg_in_if  in_if ();
  drcg_out_if out_if ();
  drcg_cfg_if cfg_if ();

  diamond_ring_coordinate_gen u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #2 clk = ~clk;

  cfg_t     shadow_cfg;
  pending_t coord_q[$];
  int       err_cnt     = 0;
  int       quiet_cycles = 0;
  int       hold_cycles  = 0;
  bit       pace_on      = 1'b1;

  task automatic report_mismatch(input string msg);
    if (err_cnt < 200) $display("MISMATCH %s", msg);
    err_cnt++;
  endtask

  function automatic int grid_span(input logic [GRID_W-1:0] g);
    if (g == '0) return 1;
    if (g > GRID_LIMIT) return int'(GRID_LIMIT);
    return int'(g);
  endfunction

  function automatic int unsigned ring_first(input int unsigned r);
    return (r == 0) ? 0 : 1 + 2 * r * (r - 1);
  endfunction

  // coordinate of one point index under the current register values
  function automatic res_t expected_coord(input logic [IDX_W-1:0] idx);
    int unsigned rest, ring, span, p, m, sx, sy, t;
    int          x, y, w, h;
    res_t        r;
    rest = idx;
    ring = 0;
    span = 1;
    while (rest >= span) begin
      rest -= span;
      ring++;
      span = 4 * ring;
    end
    p  = rest;
    m  = (p + 2) / 4;
    sx = ((p + 2) / 2) & 1;
    sy = (p + 2) & 1;
    // last two positions of a ring swap their signs
    if (ring > 0 && p >= 4 * ring - 2) begin
      t  = sx;
      sx = sy;
      sy = t;
    end
    if (m > ring) m = ring;
    x = int'(shadow_cfg.centre_x) + ((sx != 0) ? -int'(m) : int'(m));
    y = int'(shadow_cfg.centre_y) + ((sy != 0) ? -int'(ring - m) : int'(ring - m));
    w = grid_span(shadow_cfg.grid_width);
    h = grid_span(shadow_cfg.grid_height);
    r.in_grid = 1'b1;
    if (!shadow_cfg.periodic && (x < 0 || x >= w || y < 0 || y >= h)) r.in_grid = 1'b0;
    x = x % w;
    if (x < 0) x += w;
    y = y % h;
    if (y < 0) y += h;
    r.pos_x         = x[POS_W-1:0];
    r.pos_y         = y[POS_W-1:0];
    r.beyond_radius = (ring > shadow_cfg.radius);
    return r;
  endfunction

  // mostly small rings, some anywhere, some hugging the radius boundary
  function automatic logic [IDX_W-1:0] pick_index();
    int unsigned r, p, idx;
    case ($urandom_range(0, 3))
      0, 1: idx = $urandom_range(0, 600);
      2: idx = $urandom_range(0, IDX_MAX);
      default: begin
        r = shadow_cfg.radius + $urandom_range(0, 1);
        if (r == 0) begin
          p = 0;
        end else begin
          case ($urandom_range(0, 4))
            0: p = 0;
            1: p = 1;
            2: p = 4 * r - 2;
            3: p = 4 * r - 1;
            default: p = $urandom_range(0, 4 * r - 1);
          endcase
        end
        idx = ring_first(r) + p;
      end
    endcase
    if (idx > IDX_MAX) idx = IDX_MAX;
    return idx[IDX_W-1:0];
  endfunction

  function automatic int unsigned rand_grid();
    case ($urandom_range(0, 3))
      0: return $urandom_range(1, 16);
      1: return $urandom_range(1, GRID_LIMIT);
      2: return $urandom_range(0, (1 << CFG_DW) - 1);
      default: return GRID_LIMIT;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input int unsigned val);
    logic [CFG_DW-1:0] data;
    data = CFG_DW'(val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_CENTRE_X:    shadow_cfg.centre_x    = data[POS_W-1:0];
      CFG_CENTRE_Y:    shadow_cfg.centre_y    = data[POS_W-1:0];
      CFG_RADIUS:      shadow_cfg.radius      = data[RAD_W-1:0];
      CFG_GRID_WIDTH:  shadow_cfg.grid_width  = data[GRID_W-1:0];
      CFG_GRID_HEIGHT: shadow_cfg.grid_height = data[GRID_W-1:0];
      CFG_PERIODIC:    shadow_cfg.periodic    = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic configure_diamond(input int unsigned cx, input int unsigned cy,
                                   input int unsigned rad, input int unsigned gw,
                                   input int unsigned gh, input int unsigned per);
    write_reg(CFG_CENTRE_X, cx);
    write_reg(CFG_CENTRE_Y, cy);
    write_reg(CFG_RADIUS, rad);
    write_reg(CFG_GRID_WIDTH, gw);
    write_reg(CFG_GRID_HEIGHT, gh);
    write_reg(CFG_PERIODIC, per);
  endtask

  // valid stays high into the next call when that one draws no gap
  task automatic send_index(input logic [IDX_W-1:0] idx);
    int       gap;
    pending_t pend;
    gap = pace_on ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    repeat (gap) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.point_index <= idx;
    do @(posedge clk); while (!in_if.ready);
    pend.idx   = idx;
    pend.coord = expected_coord(idx);
    coord_q.push_back(pend);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (coord_q.size() != 0) @(posedge clk);
  endtask

  // result side: random ready gaps, plus one long hold on request
  initial begin : result_sink
    int       gap;
    pending_t pend;
    out_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      gap = pace_on ? $urandom_range(0, 7) : 0;
      if (hold_cycles > 0) begin
        gap         = hold_cycles;
        hold_cycles = 0;
      end
      repeat (gap) begin
        out_if.ready <= 1'b0;
        @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      if (coord_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat x=%0d y=%0d", out_if.pos_x, out_if.pos_y));
      end else begin
        pend = coord_q.pop_front();
        if (out_if.pos_x !== pend.coord.pos_x)
          report_mismatch($sformatf("index %0d pos_x got %0d want %0d",
                                    pend.idx, out_if.pos_x, pend.coord.pos_x));
        if (out_if.pos_y !== pend.coord.pos_y)
          report_mismatch($sformatf("index %0d pos_y got %0d want %0d",
                                    pend.idx, out_if.pos_y, pend.coord.pos_y));
        if (out_if.in_grid !== pend.coord.in_grid)
          report_mismatch($sformatf("index %0d in_grid got %0b want %0b",
                                    pend.idx, out_if.in_grid, pend.coord.in_grid));
        if (out_if.beyond_radius !== pend.coord.beyond_radius)
          report_mismatch($sformatf("index %0d beyond_radius got %0b want %0b",
                                    pend.idx, out_if.beyond_radius,
                                    pend.coord.beyond_radius));
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[diamond_ring_coordinate_gen] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reset registers: centre at origin, 64 x 64 torus
  task automatic test_small_rings();
    for (int i = 0; i <= 12; i++) send_index(IDX_W'(i));
    send_index(IDX_W'(IDX_MAX));
    wait_for_results();
  endtask

  task automatic test_config_extremes();
    // far corner, widest radius, flagged edges
    configure_diamond(1023, 1023, 255, 1024, 1024, 0);
    send_index(IDX_W'(ring_first(256) - 1));
    send_index(IDX_W'(ring_first(256)));
    send_index(IDX_W'(IDX_MAX));
    send_index('0);
    wait_for_results();
    // zero grid size behaves as one cell
    configure_diamond(5, 0, 0, 0, 0, 0);
    send_index('0);
    send_index(IDX_W'(3));
    wait_for_results();
    // all-ones data: masked centre/radius, oversized grid clamped
    configure_diamond(2047, 0, 2047, 2047, 2047, 1);
    send_index(IDX_W'(7));
    send_index(IDX_W'(IDX_MAX));
    wait_for_results();
    write_reg(CFG_UNMAPPED_A, 2047);
    write_reg(CFG_UNMAPPED_B, 2047);
    send_index(IDX_W'(2));
    wait_for_results();
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 9; phase++) begin
      pace_on = (phase % 3 != 2);
      case (phase)
        0: configure_diamond(0, 0, 0, 1, 1, 1);
        1: configure_diamond(1023, 0, 255, 0, 2047, 0);
        2: configure_diamond(0, 1023, 255, 1024, 1, 0);
        default: configure_diamond($urandom_range(0, 2047), $urandom_range(0, 2047),
                                   $urandom_range(0, 2047), rand_grid(), rand_grid(),
                                   $urandom_range(0, 2047));
      endcase
      repeat (60) send_index(pick_index());
      wait_for_results();
    end
    pace_on = 1'b1;
  endtask

  // result side holds off while items keep coming, so the input must stall
  task automatic test_output_backpressure();
    configure_diamond(512, 300, 40, 700, 900, 0);
    pace_on     = 1'b0;
    hold_cycles = 600;
    repeat (30) send_index(pick_index());
    wait_for_results();
    pace_on = 1'b1;
  endtask

  task automatic test_pause_until_idle();
    repeat (3) begin
      repeat (8) send_index(pick_index());
      wait_for_results();
    end
  endtask

  initial begin
    in_if.valid       = 1'b0;
    in_if.point_index = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    rst_n             = 1'b0;
    shadow_cfg.centre_x    = '0;
    shadow_cfg.centre_y    = '0;
    shadow_cfg.radius      = '0;
    shadow_cfg.grid_width  = GRID_W'(64);
    shadow_cfg.grid_height = GRID_W'(64);
    shadow_cfg.periodic    = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_small_rings();
    test_config_extremes();
    test_random_phases();
    test_output_backpressure();
    test_pause_until_idle();

    wait_for_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[diamond_ring_coordinate_gen] OK");
    end else begin
      $display("[diamond_ring_coordinate_gen] ERROR");
    end
    $finish;
  end

endmodule
